@@ rtl/core/text_console_char_writer_assert.svh @@
// assertion macros shared by the console char writer rtl
`ifndef TEXT_CONSOLE_CHAR_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_CHAR_WRITER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked on every rising edge out of reset
`define TCCW_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tccw assertion failed");

// next-cycle implication
`define TCCW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tccw assertion failed");

`else

`define TCCW_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define TCCW_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/core/tccw_pkg.sv @@
// shared types and constants of the console char writer
package tccw_pkg;

    localparam int COLUMNS_DEFAULT = 40;
    localparam int COL_W           = 6;
    localparam int CHAR_W          = 8;
    localparam int COLOR_W         = 4;

    localparam logic [CHAR_W-1:0]  CH_BS      = 8'd8;
    localparam logic [CHAR_W-1:0]  CH_DEL     = 8'd127;
    localparam logic [CHAR_W-1:0]  CH_NL      = 8'd10;
    localparam logic [CHAR_W-1:0]  CH_BLANK   = 8'd32;
    localparam logic [COLOR_W-1:0] CLEAR_FORE = 4'd0;
    localparam logic [COLOR_W-1:0] CLEAR_BACK = 4'd7;

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_SCROLL = 1'b1;

    // configuration register indexes
    localparam logic REG_TEXT_COLOR = 1'b0;
    localparam logic REG_BACK_COLOR = 1'b1;

    typedef struct packed {
        logic [COLOR_W-1:0] back;
        logic [COLOR_W-1:0] fore;
        logic [CHAR_W-1:0]  glyph;
    } cell_t;

    typedef struct packed {
        logic             kind;
        logic [COL_W-1:0] column;
        cell_t            content;
    } result_t;

    // the decoded request the emit stage holds; a cell read from the row store comes in separately
    typedef struct packed {
        result_t          first;
        logic             two;
        logic             second_from_mem;
        logic [COL_W-1:0] second_column;
        cell_t            second_cell;
    } item_desc_t;

endpackage

@@ rtl/core/text_console_char_writer.sv @@
// Bottom-line driver of a scrolling text console.
// Input channel: one char_code per request on in_valid/in_ready. Backspace (8) and
// delete (127) erase left of the cursor, newline (10) scrolls, other codes are written
// at the cursor; a code arriving at a full line scrolls first.
// Output channel: kind/column/glyph/fore/back/last on out_valid/out_ready, one to two
// results per request, last set on the final one. Backspace at column 0 gives none.
// Colors come from the APB registers text_color (0x0) and back_color (0x4).
// At the accepting edge the request is decoded into the hold stage and the row store is
// read; the hold stage then loads the output register, which sets the pace, emitting one
// result per cycle while out_ready is high. Throughput: one request per cycle while each
// yields one result and out_ready is high; two results hold in_ready low until both load.
// A stalled receiver holds the output register; one more request is taken into the
// hold stage, then in_ready drops until results drain.
// Reset clears the cursor, colors to 0/7 and all valid flags; the row store is not
// cleared, since only cells written since the last scroll are ever read back.
module text_console_char_writer
    import tccw_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [CHAR_W-1:0]  char_code,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               kind,
    output logic [COL_W-1:0]   column,
    output logic [CHAR_W-1:0]  glyph,
    output logic [COLOR_W-1:0] fore,
    output logic [COLOR_W-1:0] back,
    output logic               last
);

`include "text_console_char_writer_assert.svh"

    localparam int CUR_W  = $clog2(COLUMNS + 1);
    localparam int ADDR_W = $clog2(COLUMNS);

    logic [COLOR_W-1:0] text_color_reg;
    logic [COLOR_W-1:0] back_color_reg;
    logic [CUR_W-1:0]   cursor_reg;
    logic [CUR_W-1:0]   cursor_next;
    cell_t              row_mem [COLUMNS];
    cell_t              rd_cell_reg;

    logic               accept;
    logic               free;
    logic               is_erase;
    logic               is_nl;
    logic               scroll;
    logic               has_results;
    logic [CUR_W-1:0]   cur_dec;
    logic [CUR_W-1:0]   base;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    cell_t              wr_cell;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    cell_t              color_cell;
    cell_t              blank_cell;
    cell_t              clear_cell;
    item_desc_t         desc;
    result_t            out_result;

    // apb register port
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_color_reg <= '0;
            back_color_reg <= CLEAR_BACK;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (paddr[2])
                REG_TEXT_COLOR: text_color_reg <= pwdata[COLOR_W-1:0];
                REG_BACK_COLOR: back_color_reg <= pwdata[COLOR_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_TEXT_COLOR: prdata = 32'(text_color_reg);
            REG_BACK_COLOR: prdata = 32'(back_color_reg);
            default:        prdata = '0;
        endcase
    end

    // decode the request against the cursor
    assign accept   = in_valid && in_ready;
    assign in_ready = free;
    assign is_erase = (char_code == CH_BS) || (char_code == CH_DEL);
    assign is_nl    = (char_code == CH_NL);
    assign scroll   = !is_erase && (is_nl || (cursor_reg >= CUR_W'(COLUMNS)));
    assign cur_dec  = cursor_reg - CUR_W'(1);
    assign base     = scroll ? '0 : cursor_reg;

    assign color_cell = '{back: back_color_reg, fore: text_color_reg, glyph: char_code};
    assign blank_cell = '{back: back_color_reg, fore: text_color_reg, glyph: CH_BLANK};
    assign clear_cell = '{back: CLEAR_BACK, fore: CLEAR_FORE, glyph: CH_BLANK};

    always_comb
    begin
        cursor_next          = cursor_reg;
        has_results          = 1'b0;
        wr_en                = 1'b0;
        wr_addr              = ADDR_W'(base);
        wr_cell              = color_cell;
        rd_en                = 1'b0;
        rd_addr              = ADDR_W'(cursor_reg - CUR_W'(2));
        desc.first.kind      = KIND_WRITE;
        desc.first.column    = COL_W'(base);
        desc.first.content   = color_cell;
        desc.two             = 1'b0;
        desc.second_from_mem = 1'b0;
        desc.second_column   = '0;
        desc.second_cell     = color_cell;
        if (is_erase)
        begin
            if (cursor_reg != '0)
            begin
                has_results          = 1'b1;
                cursor_next          = cur_dec;
                wr_en                = 1'b1;
                wr_addr              = ADDR_W'(cur_dec);
                wr_cell              = blank_cell;
                desc.first.column    = COL_W'(cur_dec);
                desc.first.content   = blank_cell;
                desc.two             = (cur_dec != '0);
                rd_en                = (cur_dec != '0);
                desc.second_from_mem = 1'b1;
                desc.second_column   = COL_W'(cur_dec - CUR_W'(1));
            end
        end
        else
        begin
            has_results = 1'b1;
            if (scroll)
            begin
                desc.first.kind    = KIND_SCROLL;
                desc.first.column  = '0;
                desc.first.content = clear_cell;
                desc.two           = !is_nl;
            end
            if (is_nl)
            begin
                cursor_next = '0;
            end
            else
            begin
                wr_en       = 1'b1;
                cursor_next = base + CUR_W'(1);
            end
        end
    end

    // cursor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg <= '0;
        end
        else if (accept)
        begin
            cursor_reg <= cursor_next;
        end
    end

    // bottom-row store, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (accept && wr_en)
        begin
            row_mem[wr_addr] <= wr_cell;
        end
        if (accept && rd_en)
        begin
            rd_cell_reg <= row_mem[rd_addr];
        end
    end

    tccw_emit u_emit
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept && has_results),
        .desc       (desc),
        .mem_cell   (rd_cell_reg),
        .free       (free),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_result (out_result),
        .out_last   (last)
    );

    assign kind   = out_result.kind;
    assign column = out_result.column;
    assign glyph  = out_result.content.glyph;
    assign fore   = out_result.content.fore;
    assign back   = out_result.content.back;

    // cursor never passes the line end
    `TCCW_ASSERT_IMPL(a_cursor_range, clk, rst_n, 1'b1, cursor_reg <= CUR_W'(COLUMNS))
    // newline always returns the cursor to column zero
    `TCCW_ASSERT_NEXT(a_nl_home, clk, rst_n, accept && is_nl, cursor_reg == '0)
    // erase steps the cursor back by exactly one
    `TCCW_ASSERT_NEXT(a_erase_step, clk, rst_n, accept && is_erase && (cursor_reg != '0),
        cursor_reg == $past(cursor_reg) - CUR_W'(1))

endmodule

@@ rtl/core/tccw_emit.sv @@
// holds one decoded request and emits its one or two results through an output register
module tccw_emit
    import tccw_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  item_desc_t          desc,
    input  cell_t               mem_cell,
    output logic                free,
    output logic                out_valid,
    input  logic                out_ready,
    output result_t             out_result,
    output logic                out_last
);

`include "text_console_char_writer_assert.svh"

    logic       hold_valid_reg;
    item_desc_t hold_desc_reg;
    logic       phase_reg;
    logic       out_valid_reg;
    result_t    out_result_reg;
    logic       out_last_reg;

    result_t    cur_result;
    logic       cur_last;
    logic       out_load;
    logic       hold_done;

    // pick the result for the current phase
    always_comb
    begin
        if (!phase_reg)
        begin
            cur_result = hold_desc_reg.first;
        end
        else
        begin
            cur_result.kind    = KIND_WRITE;
            cur_result.column  = hold_desc_reg.second_column;
            cur_result.content = hold_desc_reg.second_from_mem ? mem_cell
                                                               : hold_desc_reg.second_cell;
        end
        cur_last = phase_reg || !hold_desc_reg.two;
    end

    assign out_load  = hold_valid_reg && (!out_valid_reg || out_ready);
    assign hold_done = out_load && cur_last;
    assign free      = !hold_valid_reg || hold_done;

    // hold stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            phase_reg      <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                hold_valid_reg <= 1'b1;
                phase_reg      <= 1'b0;
            end
            else if (hold_done)
            begin
                hold_valid_reg <= 1'b0;
                phase_reg      <= 1'b0;
            end
            else if (out_load)
            begin
                phase_reg <= 1'b1;
            end
        end
    end

    // hold stage payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            hold_desc_reg <= desc;
        end
    end

    // output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_result_reg <= cur_result;
            out_last_reg   <= cur_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_result_reg;
    assign out_last   = out_last_reg;

    // second phase only exists for a held two-result request
    `TCCW_ASSERT_IMPL(a_phase_held, clk, rst_n, phase_reg,
        hold_valid_reg && hold_desc_reg.two)
    // a scroll marker always describes the cleared row
    `TCCW_ASSERT_IMPL(a_scroll_shape, clk, rst_n,
        out_valid_reg && (out_result_reg.kind == KIND_SCROLL),
        (out_result_reg.column == '0) && (out_result_reg.content.glyph == CH_BLANK)
        && (out_result_reg.content.fore == CLEAR_FORE)
        && (out_result_reg.content.back == CLEAR_BACK))
    // a new request is never loaded over one still emitting
    `TCCW_ASSERT_IMPL(a_no_overrun, clk, rst_n, load, free)

endmodule
